### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the lock unit RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### design/rmfh_pkg.sv
// ---------------------------------------------------------------------------
// rmfh_pkg
// Types and constants for the recursive mutex lock unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmfh_pkg;

    // Field widths
    localparam int TASK_W    = 4;
    localparam int STATUS_W  = 4;
    localparam int COUNT_W   = 8;
    localparam int WAITING_W = 5;

    // Default wait queue depth
    localparam int WAIT_DEPTH_DEF = 16;

    // Nesting limit, clipped to what the count register holds
    localparam int NEST_MAX = 255;
    localparam logic [COUNT_W-1:0] NEST_LIMIT =
        COUNT_W'((NEST_MAX > 255) ? 255 : NEST_MAX);

    // Request kinds
    localparam logic KIND_LOCK   = 1'b0;
    localparam logic KIND_UNLOCK = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED   = 4'd0,
        ST_NESTED     = 4'd1,
        ST_BLOCKED    = 4'd2,
        ST_LOWERED    = 4'd3,
        ST_FREED      = 4'd4,
        ST_HANDOFF    = 4'd5,
        ST_NOT_OWNER  = 4'd6,
        ST_QUEUE_FULL = 4'd7,
        ST_NEST_OVF   = 4'd8
    } status_t;

    // Request sequencer states
    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

endpackage

`default_nettype wire

### design/rmfh_req_if.sv
// ---------------------------------------------------------------------------
// rmfh_req_if
// Request channel: lock or unlock request from a numbered task.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rmfh_req_if
    import rmfh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TASK_W-1:0] task_id;

    modport source (output valid, output kind, output task_id, input ready);
    modport sink   (input valid, input kind, input task_id, output ready);
endinterface

`default_nettype wire

### design/rmfh_rsp_if.sv
// ---------------------------------------------------------------------------
// rmfh_rsp_if
// Result channel: status and lock state after one request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rmfh_rsp_if
    import rmfh_pkg::*;
();
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic                 wake_valid;
    logic [TASK_W-1:0]    wake_task;
    logic                 owner_valid;
    logic [TASK_W-1:0]    owner_task;
    logic [COUNT_W-1:0]   hold_count;
    logic [WAITING_W-1:0] waiting;

    modport source (
        output valid, output status, output wake_valid, output wake_task,
        output owner_valid, output owner_task, output hold_count, output waiting,
        input ready
    );
    modport sink (
        input valid, input status, input wake_valid, input wake_task,
        input owner_valid, input owner_task, input hold_count, input waiting,
        output ready
    );
endinterface

`default_nettype wire

### design/recursive_mutex_fifo_handoff.sv
// ---------------------------------------------------------------------------
// recursive_mutex_fifo_handoff
// Lock unit for one recursive mutex with a FIFO wait queue of task numbers.
// ---------------------------------------------------------------------------
// Each request passes through two states: accept, while the wait queue
// memory reads the head entry, then decide, which updates the lock state,
// writes the queue and loads the result register. The registered read of
// the wait queue memory sets that split. The next request is accepted in
// the cycle after the result is loaded, while the result may still wait in
// its output register; a result that is not taken holds the unit in its
// decide cycle. The wait queue needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module recursive_mutex_fifo_handoff
    import rmfh_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    rmfh_req_if.sink    req,
    rmfh_rsp_if.source  rsp
);

    localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WAIT_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WAIT_DEPTH);

    // Wait queue memory
    logic [TASK_W-1:0] queue_mem [WAIT_DEPTH];

    fsm_state_t state_reg, state_next;

    // Lock state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TASK_W-1:0]  owner_reg, owner_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    // Captured request and head read data
    logic               kind_reg;
    logic [TASK_W-1:0]  task_reg;
    logic [TASK_W-1:0]  head_data_reg;

    // Result register
    logic                 rsp_valid_reg;
    status_t              status_reg, status_next;
    logic                 wake_valid_reg, wake_valid_next;
    logic [TASK_W-1:0]    wake_task_reg, wake_task_next;
    logic                 owner_valid_reg;
    logic [TASK_W-1:0]    owner_task_reg;
    logic [COUNT_W-1:0]   hold_count_reg;
    logic [WAITING_W-1:0] waiting_reg;

    logic               in_xfer;
    logic               exec_fire;
    logic               queue_we;
    logic [COUNT_W-1:0] count_dec;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            FSM_IDLE: req.ready = 1'b1;
            FSM_EXEC: exec_fire = !rsp_valid_reg || rsp.ready;
            default:
            begin
                req.ready = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    assign in_xfer   = req.valid && req.ready;
    assign count_dec = count_reg - COUNT_W'(1);

    // Request decision and state update
    always_comb
    begin
        count_next      = count_reg;
        owner_next      = owner_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        status_next     = ST_NOT_OWNER;
        wake_valid_next = 1'b0;
        wake_task_next  = '0;
        queue_we        = 1'b0;
        if (kind_reg == KIND_LOCK)
        begin
            if (count_reg == '0)
            begin
                count_next  = COUNT_W'(1);
                owner_next  = task_reg;
                status_next = ST_ACQUIRED;
            end
            else if (owner_reg == task_reg)
            begin
                if (count_reg >= NEST_LIMIT)
                begin
                    status_next = ST_NEST_OVF;
                end
                else
                begin
                    count_next  = count_reg + COUNT_W'(1);
                    status_next = ST_NESTED;
                end
            end
            else if (fill_reg >= FILL_FULL)
            begin
                status_next = ST_QUEUE_FULL;
            end
            else
            begin
                queue_we    = 1'b1;
                tail_next   = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                fill_next   = fill_reg + FILL_W'(1);
                status_next = ST_BLOCKED;
            end
        end
        else if (count_reg != '0 && owner_reg == task_reg)
        begin
            if (count_dec != '0)
            begin
                count_next  = count_dec;
                status_next = ST_LOWERED;
            end
            else if (fill_reg == '0)
            begin
                count_next  = '0;
                owner_next  = '0;
                status_next = ST_FREED;
            end
            else
            begin
                // Hand the lock to the head waiter
                count_next      = COUNT_W'(1);
                owner_next      = head_data_reg;
                head_next       = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
                fill_next       = fill_reg - FILL_W'(1);
                wake_valid_next = 1'b1;
                wake_task_next  = head_data_reg;
                status_next     = ST_HANDOFF;
            end
        end
    end

    // Wait queue write
    always_ff @(posedge clk)
    begin
        if (exec_fire && queue_we)
        begin
            queue_mem[tail_reg] <= task_reg;
        end
    end

    // Wait queue read; head is stable from accept through the decide cycle
    always_ff @(posedge clk)
    begin
        head_data_reg <= queue_mem[head_reg];
    end

    // Captured request
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= req.kind;
            task_reg <= req.task_id;
        end
    end

    // Control and lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            owner_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                count_reg     <= count_next;
                owner_reg     <= owner_next;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg      <= status_next;
            wake_valid_reg  <= wake_valid_next;
            wake_task_reg   <= wake_task_next;
            owner_valid_reg <= (count_next != '0);
            owner_task_reg  <= (count_next != '0) ? owner_next : '0;
            hold_count_reg  <= count_next;
            waiting_reg     <= WAITING_W'(fill_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.wake_valid  = wake_valid_reg;
    assign rsp.wake_task   = wake_task_reg;
    assign rsp.owner_valid = owner_valid_reg;
    assign rsp.owner_task  = owner_task_reg;
    assign rsp.hold_count  = hold_count_reg;
    assign rsp.waiting     = waiting_reg;

    // Checks
    `ASSERT_IMPLIES(a_free_no_owner, clk, rst_n, count_reg == '0, owner_reg == '0)
    `ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_FULL)
    `ASSERT_IMPLIES(a_empty_ptrs, clk, rst_n, fill_reg == '0, head_reg == tail_reg)
    `ASSERT_IMPLIES(a_wake_owner, clk, rst_n, rsp_valid_reg && wake_valid_reg, owner_valid_reg && owner_task_reg == wake_task_reg && status_reg == ST_HANDOFF)
    `ASSERT_NEXT(a_accept_exec, clk, rst_n, in_xfer, state_reg == FSM_EXEC)

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the recursive mutex lock unit. A short table of
// requests walks all statuses but queue full and nest overflow with hand-computed
// results, then scripted climbs, queue fills and random contention run
// against a behavioral copy of the lock, with random idling and stalls on both channels.
// ---------------------------------------------------------------------------

module tb;
    import rmfh_pkg::*;

    localparam int Q_DEPTH     = WAIT_DEPTH_DEF;
    localparam int QP_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int TOTAL_ITEMS = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 80;
    localparam int TAIL_CYCLES = 20;

    // One result of the lock unit
    typedef struct packed {
        status_t              status;
        logic                 wake_valid;
        logic [TASK_W-1:0]    wake_task;
        logic                 owner_valid;
        logic [TASK_W-1:0]    owner_task;
        logic [COUNT_W-1:0]   hold_count;
        logic [WAITING_W-1:0] waiting;
    } lock_result_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        logic         kind;
        logic [TASK_W-1:0] task_id;
        bit           typed;
        lock_result_t want;
    } req_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rmfh_req_if req_ch ();
    rmfh_rsp_if rsp_ch ();

    recursive_mutex_fifo_handoff u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Shadow copy of the lock state
    logic [COUNT_W-1:0] mx_count = '0;
    logic [TASK_W-1:0]  mx_owner = '0;
    logic [TASK_W-1:0]  mx_ring [Q_DEPTH];
    logic [QP_W-1:0]    mx_head = '0;
    logic [QP_W-1:0]    mx_tail = '0;
    int                 mx_fill = 0;

    lock_result_t pending_results [$];
    req_row_t     dir_rows [$];

    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int st_seen [0:8];
    bit quiet = 1'b0;
    bit stall_ask = 1'b0;
    int stall_left = 0;

    // Apply one request to the shadow lock and return its result
    function automatic lock_result_t lock_unit_step(input logic kind,
                                                    input logic [TASK_W-1:0] tid);
        lock_result_t r;
        r = '0;
        r.status = ST_NOT_OWNER;
        if (kind == KIND_LOCK)
        begin
            if (mx_count == 0)
            begin
                mx_count = COUNT_W'(1);
                mx_owner = tid;
                r.status = ST_ACQUIRED;
            end
            else if (mx_owner == tid)
            begin
                if (mx_count >= NEST_LIMIT)
                    r.status = ST_NEST_OVF;
                else
                begin
                    mx_count = mx_count + 1'b1;
                    r.status = ST_NESTED;
                end
            end
            else if (mx_fill >= Q_DEPTH)
                r.status = ST_QUEUE_FULL;
            else
            begin
                mx_ring[mx_tail] = tid;
                mx_tail = (mx_tail == QP_W'(Q_DEPTH - 1)) ? '0 : mx_tail + 1'b1;
                mx_fill++;
                r.status = ST_BLOCKED;
            end
        end
        else if (mx_count != 0 && mx_owner == tid)
        begin
            mx_count = mx_count - 1'b1;
            if (mx_count != 0)
                r.status = ST_LOWERED;
            else if (mx_fill == 0)
            begin
                mx_owner = '0;
                r.status = ST_FREED;
            end
            else
            begin
                // count hit zero with waiters: head of the queue takes over
                mx_owner = mx_ring[mx_head];
                mx_head = (mx_head == QP_W'(Q_DEPTH - 1)) ? '0 : mx_head + 1'b1;
                mx_fill--;
                mx_count = COUNT_W'(1);
                r.wake_valid = 1'b1;
                r.wake_task = mx_owner;
                r.status = ST_HANDOFF;
            end
        end
        r.owner_valid = (mx_count != 0);
        r.owner_task = (mx_count != 0) ? mx_owner : '0;
        r.hold_count = mx_count;
        r.waiting = WAITING_W'(mx_fill);
        return r;
    endfunction

    // Any task other than the current owner
    function automatic logic [TASK_W-1:0] pick_rival();
        logic [TASK_W-1:0] t;
        t = TASK_W'($urandom_range(15));
        if (t == mx_owner)
            t = t + 1'b1;
        return t;
    endfunction

    task automatic add_row(input logic k, input int t, input bit typed, input status_t st,
                           input int wv, input int wt, input int ov, input int ot,
                           input int cnt, input int wq);
        req_row_t row;
        row.kind = k;
        row.task_id = TASK_W'(t);
        row.typed = typed;
        row.want = '{st, wv[0], TASK_W'(wt), ov[0], TASK_W'(ot), COUNT_W'(cnt),
                     WAITING_W'(wq)};
        dir_rows.push_back(row);
    endtask

    // Present one request, wait for its transfer, record the expected result
    task automatic issue(input logic k, input logic [TASK_W-1:0] t,
                         input bit typed = 1'b0, input lock_result_t want = '0);
        lock_result_t got;
        quiet = (n_sent >= 450 && n_sent < 600);
        if (!quiet && $urandom_range(99) < 20)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= k;
        req_ch.task_id <= t;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        got = lock_unit_step(k, t);
        pending_results.push_back(typed ? want : got);
        n_sent++;
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic drain_wait();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Fill the wait queue past its depth, then hand the lock down the line
    task automatic queue_burst();
        if (mx_count == 0)
            issue(KIND_LOCK, TASK_W'($urandom_range(15)));
        while (mx_fill < Q_DEPTH)
        begin
            if ($urandom_range(99) < 10)
                issue(KIND_UNLOCK, pick_rival());
            else
                issue(KIND_LOCK, pick_rival());
        end
        repeat ($urandom_range(3, 1))
            issue(KIND_LOCK, pick_rival());
        while (mx_fill != 0)
        begin
            if ($urandom_range(99) < 15)
                issue(KIND_LOCK, mx_owner);
            else
                issue(KIND_UNLOCK, mx_owner);
        end
        while (mx_count != 0)
            issue(KIND_UNLOCK, mx_owner);
    endtask

    // Mixed traffic: random lockers, the owner releasing, stray unlocks
    task automatic contend(input int len);
        int r;
        repeat (len)
        begin
            r = $urandom_range(99);
            if (r < 35)
                issue(KIND_LOCK, TASK_W'($urandom_range(15)));
            else if (r < 75 && mx_count != 0)
                issue(KIND_UNLOCK, mx_owner);
            else
                issue(KIND_UNLOCK, TASK_W'($urandom_range(15)));
        end
    endtask

    task automatic noise(input int len);
        repeat (len)
            issue(1'($urandom_range(1)), TASK_W'($urandom_range(15)));
    endtask

    // Stimulus
    initial
    begin : stimulus
        int n_ovf;
        int r;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_LOCK;
        req_ch.task_id = '0;
        foreach (st_seen[i])
            st_seen[i] = 0;

        // Directed: kind, task, typed, status, wake v/t, owner v/t, count, waiting
        add_row(KIND_UNLOCK,  5, 1, ST_NOT_OWNER, 0,  0, 0,  0, 0, 0);  // unlock while free
        add_row(KIND_LOCK,    0, 1, ST_ACQUIRED,  0,  0, 1,  0, 1, 0);
        add_row(KIND_LOCK,    0, 1, ST_NESTED,    0,  0, 1,  0, 2, 0);
        add_row(KIND_LOCK,   15, 1, ST_BLOCKED,   0,  0, 1,  0, 2, 1);
        add_row(KIND_LOCK,    7, 1, ST_BLOCKED,   0,  0, 1,  0, 2, 2);
        add_row(KIND_LOCK,   15, 1, ST_BLOCKED,   0,  0, 1,  0, 2, 3);  // waiter queued again
        add_row(KIND_UNLOCK, 15, 1, ST_NOT_OWNER, 0,  0, 1,  0, 2, 3);
        add_row(KIND_UNLOCK,  0, 1, ST_LOWERED,   0,  0, 1,  0, 1, 3);
        add_row(KIND_UNLOCK,  0, 1, ST_HANDOFF,   1, 15, 1, 15, 1, 2);
        add_row(KIND_LOCK,   15, 1, ST_NESTED,    0,  0, 1, 15, 2, 2);
        add_row(KIND_UNLOCK, 15, 1, ST_LOWERED,   0,  0, 1, 15, 1, 2);
        add_row(KIND_UNLOCK, 15, 1, ST_HANDOFF,   1,  7, 1,  7, 1, 1);
        add_row(KIND_UNLOCK,  7, 1, ST_HANDOFF,   1, 15, 1, 15, 1, 0);  // third entry served
        add_row(KIND_UNLOCK, 15, 1, ST_FREED,     0,  0, 0,  0, 0, 0);
        add_row(KIND_UNLOCK, 15, 1, ST_NOT_OWNER, 0,  0, 0,  0, 0, 0);
        add_row(KIND_LOCK,   10, 0, ST_ACQUIRED,  0,  0, 0,  0, 0, 0);
        add_row(KIND_LOCK,    5, 0, ST_ACQUIRED,  0,  0, 0,  0, 0, 0);
        add_row(KIND_UNLOCK,  5, 0, ST_ACQUIRED,  0,  0, 0,  0, 0, 0);
        add_row(KIND_UNLOCK, 10, 0, ST_ACQUIRED,  0,  0, 0,  0, 0, 0);
        add_row(KIND_UNLOCK,  5, 0, ST_ACQUIRED,  0,  0, 0,  0, 0, 0);

        @(posedge rst_n);
        @(posedge clk);
        foreach (dir_rows[i])
            issue(dir_rows[i].kind, dir_rows[i].task_id, dir_rows[i].typed, dir_rows[i].want);

        // Climb to the nesting limit and past it; receiver stalls meanwhile
        stall_ask = 1'b1;
        if (mx_count == 0)
            issue(KIND_LOCK, TASK_W'($urandom_range(15)));
        n_ovf = 0;
        while (n_ovf < 3)
        begin
            r = $urandom_range(99);
            if (r < 88)
            begin
                if (mx_count == NEST_LIMIT)
                    n_ovf++;
                issue(KIND_LOCK, mx_owner);
            end
            else if (r < 95)
                issue(KIND_LOCK, pick_rival());
            else
                issue(KIND_UNLOCK, pick_rival());
        end

        // Unwind the nesting
        while (mx_count > 1)
        begin
            if ($urandom_range(99) < 92)
                issue(KIND_UNLOCK, mx_owner);
            else
                issue(KIND_UNLOCK, pick_rival());
        end
        drain_wait();

        queue_burst();

        // Random mix until the item budget is spent
        while (n_sent < TOTAL_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 15)
                noise($urandom_range(20, 5));
            else if (r < 40)
                queue_burst();
            else
                contend($urandom_range(40, 10));
        end

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d requests, checked %0d results: %0d handoffs, %0d queue full,",
                 n_sent, n_results, st_seen[ST_HANDOFF], st_seen[ST_QUEUE_FULL]);
        $display("%0d nest overflows, %0d not-owner unlocks, %0d mismatches.",
                 st_seen[ST_NEST_OVF], st_seen[ST_NOT_OWNER], n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random backpressure, one long stall on request
    initial
    begin : result_sink
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_ask)
            begin
                stall_ask = 1'b0;
                stall_left = LONG_STALL;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= quiet || ($urandom_range(99) >= 20);
        end
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("MISMATCH at %0t, result %0d: %s", $time, n_results, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        lock_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with nothing pending, status %0d",
                                          rsp_ch.status));
            else
            begin
                want = pending_results.pop_front();
                check_field("status",      8'(rsp_ch.status),      8'(want.status));
                check_field("wake_valid",  8'(rsp_ch.wake_valid),  8'(want.wake_valid));
                check_field("wake_task",   8'(rsp_ch.wake_task),   8'(want.wake_task));
                check_field("owner_valid", 8'(rsp_ch.owner_valid), 8'(want.owner_valid));
                check_field("owner_task",  8'(rsp_ch.owner_task),  8'(want.owner_task));
                check_field("hold_count",  rsp_ch.hold_count,      want.hold_count);
                check_field("waiting",     8'(rsp_ch.waiting),     8'(want.waiting));
            end
            if (rsp_ch.status <= ST_NEST_OVF)
                st_seen[rsp_ch.status]++;
            n_results++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+design
design/rmfh_pkg.sv
design/rmfh_req_if.sv
design/rmfh_rsp_if.sv
design/recursive_mutex_fifo_handoff.sv
tb/tb.sv
